FILE: hdl/hhjc_pkg.sv
`default_nettype none
package hhjc_pkg;

  // Default longest key kept; longer keys are truncated
  localparam int KEY_MAX_DEF = 32;
  // Key count width covers key lengths up to 63
  localparam int KEY_CNT_W = 6;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  // Outstanding key replays: queue depth, one executing, one in flight
  localparam int PAIR_CNT_W = 4;

  // Character codes
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Work handed from front to back
  typedef enum logic [2:0] {
    CMD_BYTE,         // emit data
    CMD_CR_BYTE,      // emit CR, then data
    CMD_PAIR,         // emit data (separator), "key":"
    CMD_CLOSE,        // emit closing brace, last
    CMD_CLOSE_EMPTY   // emit opening and closing brace, last
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             data;
    logic [KEY_CNT_W-1:0]   count;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/hhjc_front.sv
`default_nettype none
module hhjc_front #(
  parameter int KEY_MAX = hhjc_pkg::KEY_MAX_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [7:0]         in_byte,
  input  wire                in_first,
  output logic               q_push,
  output hhjc_pkg::cmd_t     q_data,
  input  wire                q_full,
  input  wire                pair_done,
  output logic               wr_en,
  output logic [((KEY_MAX > 1) ? $clog2(KEY_MAX) : 1)-1:0] wr_addr,
  output logic [7:0]         wr_data
);

  localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW = hhjc_pkg::KEY_CNT_W;

  typedef enum logic [2:0] {
    PH_REQ, PH_REQ_CR, PH_KEY, PH_KEY_CR, PH_SKIP, PH_VAL, PH_VAL_CR, PH_DONE
  } phase_t;

  phase_t                              phase, phase_next, ph;
  logic [CW-1:0]                       key_count, key_count_next, kc;
  logic                                pair_emitted, pair_emitted_next, pe;
  logic [hhjc_pkg::PAIR_CNT_W-1:0]     pair_cnt;
  logic                                hold, room, absorb, wr_need, take, step, pair_push;

  // Effective state after an optional restart on the first byte
  always_comb begin
    ph = in_first ? PH_REQ : phase;
    kc = in_first ? '0 : key_count;
    pe = in_first ? 1'b0 : pair_emitted;
  end

  assign hold   = (pair_cnt != '0);
  assign room   = (kc < CW'(KEY_MAX));
  // CR not followed by LF inside a key: store the CR first, keep the byte
  assign absorb = (ph == PH_KEY_CR) && (in_byte != hhjc_pkg::CH_LF);
  assign wr_need = room && (absorb ||
                   ((ph == PH_KEY) && (in_byte != hhjc_pkg::CH_COLON) &&
                    (in_byte != hhjc_pkg::CH_CR)));

  // Key store is not written while a replay may still read it
  assign in_stall = q_full || absorb || (wr_need && hold);
  assign take     = in_valid && !in_stall;
  assign step     = in_valid && absorb && !(wr_need && hold);

  assign wr_en   = (take || step) && wr_need;
  assign wr_addr = kc[IDX_W-1:0];
  assign wr_data = step ? hhjc_pkg::CH_CR : in_byte;

  // Parser next state and command
  always_comb begin
    phase_next        = phase;
    key_count_next    = key_count;
    pair_emitted_next = pair_emitted;
    q_push            = 1'b0;
    q_data.kind       = hhjc_pkg::CMD_BYTE;
    q_data.data       = in_byte;
    q_data.count      = kc;
    if (step) begin
      phase_next = PH_KEY;
      if (room) key_count_next = kc + CW'(1);
    end else if (take) begin
      phase_next        = ph;
      key_count_next    = kc;
      pair_emitted_next = pe;
      unique case (ph)
        PH_REQ: begin
          if (in_byte == hhjc_pkg::CH_CR) phase_next = PH_REQ_CR;
        end
        PH_REQ_CR: begin
          if (in_byte == hhjc_pkg::CH_LF) begin
            phase_next     = PH_KEY;
            key_count_next = '0;
          end else if (in_byte != hhjc_pkg::CH_CR) begin
            phase_next = PH_REQ;
          end
        end
        PH_KEY: begin
          if (in_byte == hhjc_pkg::CH_COLON) begin
            q_push      = 1'b1;
            q_data.kind = hhjc_pkg::CMD_PAIR;
            q_data.data = pe ? hhjc_pkg::CH_COMMA : hhjc_pkg::CH_LBRACE;
            phase_next  = PH_SKIP;
          end else if (in_byte == hhjc_pkg::CH_CR) begin
            phase_next = PH_KEY_CR;
          end else if (room) begin
            key_count_next = kc + CW'(1);
          end
        end
        PH_KEY_CR: begin
          // only LF gets here; other bytes go through the absorb step
          if (kc == '0) begin
            q_push      = 1'b1;
            q_data.kind = pe ? hhjc_pkg::CMD_CLOSE : hhjc_pkg::CMD_CLOSE_EMPTY;
            phase_next  = PH_DONE;
          end else begin
            phase_next     = PH_KEY;
            key_count_next = '0;
          end
        end
        PH_SKIP: begin
          phase_next = (in_byte == hhjc_pkg::CH_CR) ? PH_VAL_CR : PH_VAL;
        end
        PH_VAL: begin
          if (in_byte == hhjc_pkg::CH_CR) phase_next = PH_VAL_CR;
          else q_push = 1'b1;
        end
        PH_VAL_CR: begin
          q_push = 1'b1;
          if (in_byte == hhjc_pkg::CH_LF) begin
            q_data.data       = hhjc_pkg::CH_QUOTE;
            pair_emitted_next = 1'b1;
            key_count_next    = '0;
            phase_next        = PH_KEY;
          end else if (in_byte == hhjc_pkg::CH_CR) begin
            q_data.data = hhjc_pkg::CH_CR;
          end else begin
            q_data.kind = hhjc_pkg::CMD_CR_BYTE;
            phase_next  = PH_VAL;
          end
        end
        PH_DONE: begin
        end
      endcase
    end
  end

  assign pair_push = q_push && (q_data.kind == hhjc_pkg::CMD_PAIR);

  // Parser state and count of key replays not yet finished
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_REQ;
      key_count    <= '0;
      pair_emitted <= 1'b0;
      pair_cnt     <= '0;
    end else begin
      phase        <= phase_next;
      key_count    <= key_count_next;
      pair_emitted <= pair_emitted_next;
      pair_cnt     <= pair_cnt + hhjc_pkg::PAIR_CNT_W'(pair_push)
                      - hhjc_pkg::PAIR_CNT_W'(pair_done);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hhjc_queue.sv
`default_nettype none
module hhjc_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  hhjc_pkg::cmd_t  push_data,
  output logic            full,
  input  wire             pop,
  output logic            valid,
  output hhjc_pkg::cmd_t  pop_data
);

  hhjc_pkg::cmd_t                   entries [hhjc_pkg::Q_DEPTH];
  logic [hhjc_pkg::Q_PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [hhjc_pkg::Q_CNT_W-1:0]     count;

  assign full     = (count == hhjc_pkg::Q_CNT_W'(hhjc_pkg::Q_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  // Command storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + hhjc_pkg::Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + hhjc_pkg::Q_PTR_W'(1);
      count <= count + hhjc_pkg::Q_CNT_W'(push) - hhjc_pkg::Q_CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hhjc_back.sv
`default_nettype none
module hhjc_back #(
  parameter int KEY_MAX = hhjc_pkg::KEY_MAX_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  hhjc_pkg::cmd_t     q_data,
  output logic               q_pop,
  input  wire                wr_en,
  input  wire  [((KEY_MAX > 1) ? $clog2(KEY_MAX) : 1)-1:0] wr_addr,
  input  wire  [7:0]         wr_data,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               pair_done
);

  localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW = hhjc_pkg::KEY_CNT_W;

  typedef enum logic [2:0] {
    B_IDLE, B_SECOND, B_QOPEN, B_FETCH, B_KEY, B_QCLOSE, B_COLON, B_QVAL
  } bstate_t;

  bstate_t          state;
  logic [7:0]       key_mem [KEY_MAX];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] idx;
  logic [CW-1:0]    cnt;
  logic [7:0]       sec_byte;
  logic             sec_last;
  logic             free;
  logic             load;

  assign free  = !out_valid || !out_stall;
  assign q_pop = (state == B_IDLE) && q_valid && free;
  // output register takes a new byte in every state except the key fetch; in idle only when a command waits
  assign load  = free && ((state == B_IDLE) ? q_valid : (state != B_FETCH));

  // Key store: written by the front, read during replay
  always_ff @(posedge clk) begin
    if (wr_en) key_mem[wr_addr] <= wr_data;
    rd_data <= key_mem[idx];
  end

  // Command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      pair_done <= 1'b0;
    end else begin
      pair_done <= (state == B_QVAL) && free;
      if (free) out_valid <= load;
      unique case (state)
        B_IDLE: begin
          if (q_valid && free) begin
            unique case (q_data.kind)
              hhjc_pkg::CMD_CR_BYTE: begin
                out_byte <= hhjc_pkg::CH_CR;
                out_last <= 1'b0;
                sec_byte <= q_data.data;
                sec_last <= 1'b0;
                state    <= B_SECOND;
              end
              hhjc_pkg::CMD_PAIR: begin
                out_byte <= q_data.data;
                out_last <= 1'b0;
                cnt      <= q_data.count;
                idx      <= '0;
                state    <= B_QOPEN;
              end
              hhjc_pkg::CMD_CLOSE: begin
                out_byte <= hhjc_pkg::CH_RBRACE;
                out_last <= 1'b1;
              end
              hhjc_pkg::CMD_CLOSE_EMPTY: begin
                out_byte <= hhjc_pkg::CH_LBRACE;
                out_last <= 1'b0;
                sec_byte <= hhjc_pkg::CH_RBRACE;
                sec_last <= 1'b1;
                state    <= B_SECOND;
              end
              default: begin
                out_byte <= q_data.data;
                out_last <= 1'b0;
              end
            endcase
          end
        end
        B_SECOND: begin
          if (free) begin
            out_byte  <= sec_byte;
            out_last  <= sec_last;
            state     <= B_IDLE;
          end
        end
        B_QOPEN: begin
          if (free) begin
            out_byte  <= hhjc_pkg::CH_QUOTE;
            out_last  <= 1'b0;
            state     <= (cnt == '0) ? B_QCLOSE : B_FETCH;
          end
        end
        B_FETCH: begin
          // memory read of key byte idx completes here
          state <= B_KEY;
        end
        B_KEY: begin
          if (free) begin
            out_byte  <= rd_data;
            out_last  <= 1'b0;
            if (CW'(idx) + CW'(1) == cnt) begin
              state <= B_QCLOSE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= B_FETCH;
            end
          end
        end
        B_QCLOSE: begin
          if (free) begin
            out_byte  <= hhjc_pkg::CH_QUOTE;
            out_last  <= 1'b0;
            state     <= B_COLON;
          end
        end
        B_COLON: begin
          if (free) begin
            out_byte  <= hhjc_pkg::CH_COLON;
            out_last  <= 1'b0;
            state     <= B_QVAL;
          end
        end
        B_QVAL: begin
          if (free) begin
            out_byte  <= hhjc_pkg::CH_QUOTE;
            out_last  <= 1'b0;
            state     <= B_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/http_header_to_json_converter.sv
// A value byte passes through the command queue and then the output register.
// Throughput: one request per cycle while the output is taken and the queue has room;
// a lone CR in a key stalls the input while the CR is stored, and key bytes wait while
// an earlier key replay runs. A colon replays the key (registered key store read).
// Reset: synchronous rst clears the parser, queue and output valid; the key store is
// not cleared and holds no valid data until a key is written.
`default_nettype none
module http_header_to_json_converter #(
  parameter int KEY_MAX = hhjc_pkg::KEY_MAX_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte,
  input  wire        in_first,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  hhjc_pkg::cmd_t   push_data, pop_data;
  logic             q_push, q_full, q_pop, q_valid;
  logic             pair_done, wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  // Parser: classifies bytes, fills the key store, issues commands
  hhjc_front #(.KEY_MAX(KEY_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_first  (in_first),
    .q_push    (q_push),
    .q_data    (push_data),
    .q_full    (q_full),
    .pair_done (pair_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Command queue
  hhjc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  // Emitter: expands commands into JSON text
  hhjc_back #(.KEY_MAX(KEY_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .pair_done (pair_done)
  );

endmodule
`default_nettype wire

FILE: tb/tb_http_header_to_json_converter.sv
`default_nettype none
module tb_http_header_to_json_converter;

  localparam int KEY_LIM   = hhjc_pkg::KEY_MAX_DEF;
  localparam int RND_ITEMS = 340;
  localparam int PRED      = -1;  // row is checked against the converter model

  // Parser states of the converter model
  typedef enum logic [2:0] {
    ST_REQ_LINE, ST_REQ_CR, ST_KEY, ST_KEY_CR, ST_SKIP, ST_VALUE, ST_VALUE_CR, ST_DONE
  } conv_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } json_char_t;

  // Directed row: input byte, first flag, typed result count (or PRED), typed bytes, last flag
  typedef struct packed {
    logic [7:0] b;
    logic       f;
    int         n;
    logic [7:0] e0;
    logic [7:0] e1;
    logic       el;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [29] = '{
    // request line ending in byte FF, CR CR LF, then a blank line: empty object
    '{8'h47, 1'b1, 0, 8'h00, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 2, hhjc_pkg::CH_LBRACE, hhjc_pkg::CH_RBRACE, 1'b1},
    // after the object: ignored
    '{8'h00, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    // restart; empty request line; key with a lone CR inside, empty value
    '{hhjc_pkg::CH_CR, 1'b1, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{8'h61, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{8'h62, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_COLON, 1'b0, PRED, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 1, hhjc_pkg::CH_QUOTE, 8'h00, 1'b0},
    // line without colon is dropped; the colon on the next line gets an empty key
    '{8'h78, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_COLON, 1'b0, PRED, 8'h00, 8'h00, 1'b0},
    '{8'h20, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1, 8'hFF, 8'h00, 1'b0},
    // CR CR x inside the value, then line end and end of object
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 1, hhjc_pkg::CH_CR, 8'h00, 1'b0},
    '{8'h00, 1'b0, 2, hhjc_pkg::CH_CR, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 1, hhjc_pkg::CH_QUOTE, 8'h00, 1'b0},
    '{hhjc_pkg::CH_CR, 1'b0, 0, 8'h00, 8'h00, 1'b0},
    '{hhjc_pkg::CH_LF, 1'b0, 1, hhjc_pkg::CH_RBRACE, 8'h00, 1'b1}
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_first  = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int snd_idle = 31;
  int rcv_idle = 74;
  int err_cnt  = 0;
  int req_items = 0;

  // converter model state
  conv_state_t conv_st   = ST_REQ_LINE;
  logic [7:0]  key_buf [KEY_LIM];
  int          key_len   = 0;
  logic        pair_done = 1'b0;
  json_char_t  new_chars[$];
  json_char_t  pending_json[$];

  always #1 clk = ~clk;

  http_header_to_json_converter u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_first (in_first),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------- converter model ----------------
  function automatic void emit(input logic [7:0] c, input logic last);
    new_chars.push_back('{c, last});
  endfunction

  function automatic void keep_key(input logic [7:0] c);
    if (key_len < KEY_LIM) begin
      key_buf[key_len] = c;
      key_len++;
    end
  endfunction

  // byte while collecting a key; the colon replays the key as "key":"
  function automatic void key_char(input logic [7:0] c);
    if (c == hhjc_pkg::CH_COLON) begin
      emit(pair_done ? hhjc_pkg::CH_COMMA : hhjc_pkg::CH_LBRACE, 1'b0);
      emit(hhjc_pkg::CH_QUOTE, 1'b0);
      for (int i = 0; i < key_len; i++) emit(key_buf[i], 1'b0);
      emit(hhjc_pkg::CH_QUOTE, 1'b0);
      emit(hhjc_pkg::CH_COLON, 1'b0);
      emit(hhjc_pkg::CH_QUOTE, 1'b0);
      conv_st = ST_SKIP;
    end else if (c == hhjc_pkg::CH_CR) begin
      conv_st = ST_KEY_CR;
    end else begin
      keep_key(c);
    end
  endfunction

  function automatic void convert_byte(input logic [7:0] c, input logic first);
    new_chars.delete();
    if (first) begin
      conv_st   = ST_REQ_LINE;
      key_len   = 0;
      pair_done = 1'b0;
    end
    case (conv_st)
      ST_REQ_LINE: begin
        if (c == hhjc_pkg::CH_CR) conv_st = ST_REQ_CR;
      end
      ST_REQ_CR: begin
        if (c == hhjc_pkg::CH_LF) begin
          conv_st = ST_KEY;
          key_len = 0;
        end else if (c != hhjc_pkg::CH_CR) begin
          conv_st = ST_REQ_LINE;
        end
      end
      ST_KEY: key_char(c);
      ST_KEY_CR: begin
        if (c == hhjc_pkg::CH_LF) begin
          if (key_len == 0) begin
            // blank line closes the object
            if (!pair_done) emit(hhjc_pkg::CH_LBRACE, 1'b0);
            emit(hhjc_pkg::CH_RBRACE, 1'b1);
            conv_st = ST_DONE;
          end else begin
            conv_st = ST_KEY;
            key_len = 0;
          end
        end else begin
          // lone CR belongs to the key
          keep_key(hhjc_pkg::CH_CR);
          conv_st = ST_KEY;
          key_char(c);
        end
      end
      ST_SKIP: conv_st = (c == hhjc_pkg::CH_CR) ? ST_VALUE_CR : ST_VALUE;
      ST_VALUE: begin
        if (c == hhjc_pkg::CH_CR) conv_st = ST_VALUE_CR;
        else emit(c, 1'b0);
      end
      ST_VALUE_CR: begin
        if (c == hhjc_pkg::CH_LF) begin
          emit(hhjc_pkg::CH_QUOTE, 1'b0);
          pair_done = 1'b1;
          key_len   = 0;
          conv_st   = ST_KEY;
        end else if (c == hhjc_pkg::CH_CR) begin
          emit(hhjc_pkg::CH_CR, 1'b0);
        end else begin
          emit(hhjc_pkg::CH_CR, 1'b0);
          emit(c, 1'b0);
          conv_st = ST_VALUE;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------- request side ----------------
  // Offer one request, wait for it to be taken, then update the model
  task automatic send_byte(input logic [7:0] b, input logic f, input logic use_model);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_first <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_items++;
    convert_byte(b, f);
    if (use_model) begin
      foreach (new_chars[i]) pending_json.push_back(new_chars[i]);
    end
  endtask

  // Hold off until every pending JSON byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_json.size() != 0);
  endtask

  // random byte that cannot end a line or start a pair by accident
  function automatic logic [7:0] plain_byte(input logic colon_ok);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == hhjc_pkg::CH_CR || c == hhjc_pkg::CH_LF ||
           (!colon_ok && c == hhjc_pkg::CH_COLON));
    return c;
  endfunction

  // Well-formed request with random content, sometimes cut short
  task automatic send_request();
    logic [7:0] msg[$];
    int n_hdr, klen, vlen, skip_kind, cut;
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(3) == 0) msg.push_back(8'($urandom_range(255)));
      else msg.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(3) == 0) msg.push_back(hhjc_pkg::CH_CR);
    msg.push_back(hhjc_pkg::CH_CR);
    msg.push_back(hhjc_pkg::CH_LF);
    n_hdr = $urandom_range(0, 3);
    repeat (n_hdr) begin
      if ($urandom_range(7) == 0) begin
        // header line without a colon
        repeat ($urandom_range(1, 6)) msg.push_back(plain_byte(1'b0));
      end else begin
        if ($urandom_range(5) == 0) klen = $urandom_range(KEY_LIM - 2, KEY_LIM + 8);
        else klen = $urandom_range(0, 8);
        repeat (klen) begin
          msg.push_back(plain_byte(1'b0));
          if ($urandom_range(15) == 0) msg.push_back(hhjc_pkg::CH_CR);
        end
        msg.push_back(hhjc_pkg::CH_COLON);
        skip_kind = $urandom_range(5);
        // kind 0: the skipped byte is the line end's CR, so the value is empty
        if (skip_kind == 1) msg.push_back(plain_byte(1'b1));
        else if (skip_kind != 0) msg.push_back(8'h20);
        vlen = (skip_kind == 0) ? 0 : $urandom_range(0, 10);
        repeat (vlen) begin
          msg.push_back(plain_byte(1'b1));
          if ($urandom_range(11) == 0) begin
            msg.push_back(hhjc_pkg::CH_CR);
            if ($urandom_range(1) == 1) msg.push_back(hhjc_pkg::CH_CR);
          end
        end
      end
      msg.push_back(hhjc_pkg::CH_CR);
      msg.push_back(hhjc_pkg::CH_LF);
    end
    msg.push_back(hhjc_pkg::CH_CR);
    msg.push_back(hhjc_pkg::CH_LF);
    // trailing bytes after the object
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
    end
    cut = ($urandom_range(9) == 0) ? $urandom_range(1, msg.size()) : msg.size();
    for (int i = 0; i < cut; i++) send_byte(msg[i], i == 0, 1'b1);
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  // compare each taken byte with the oldest pending one
  always @(posedge clk) begin
    json_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_json.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h last %b", out_byte, out_last));
      end else begin
        want = pending_json.pop_front();
        if (out_byte !== want.ch)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("out_last %b, want %b (byte %h)",
                                    out_last, want.last, want.ch));
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int rnd_start;
    int n_noise;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      send_byte(DIR_TAB[i].b, DIR_TAB[i].f, DIR_TAB[i].n == PRED);
      if (DIR_TAB[i].n == 1) begin
        pending_json.push_back('{DIR_TAB[i].e0, DIR_TAB[i].el});
      end else if (DIR_TAB[i].n == 2) begin
        pending_json.push_back('{DIR_TAB[i].e0, 1'b0});
        pending_json.push_back('{DIR_TAB[i].e1, DIR_TAB[i].el});
      end
    end
    wait_drained();

    // random part: three idle profiles, drained between them
    rnd_start = req_items;
    while (req_items - rnd_start < RND_ITEMS) begin
      if (snd_idle == 31 && req_items - rnd_start >= RND_ITEMS / 3) begin
        wait_drained();
        snd_idle = 74;
        rcv_idle = 31;
      end else if (snd_idle == 74 && req_items - rnd_start >= 2 * RND_ITEMS / 3) begin
        wait_drained();
        snd_idle = 0;
        rcv_idle = 0;
      end
      if ($urandom_range(9) == 0) begin
        // noise: random bytes, line ends and colons, with stray restarts
        n_noise = $urandom_range(4, 20);
        for (int i = 0; i < n_noise; i++) begin
          case ($urandom_range(5))
            0:       send_byte(hhjc_pkg::CH_CR, $urandom_range(19) == 0, 1'b1);
            1:       send_byte(hhjc_pkg::CH_LF, $urandom_range(19) == 0, 1'b1);
            2:       send_byte(hhjc_pkg::CH_COLON, $urandom_range(19) == 0, 1'b1);
            default: send_byte(8'($urandom_range(255)),
                               (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0),
                               1'b1);
          endcase
        end
      end else begin
        send_request();
      end
    end

    // drain, then allow for a late key replay
    in_valid <= 1'b0;
    for (int w = 0; w < 50000 && pending_json.size() != 0; w++) @(posedge clk);
    if (pending_json.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", pending_json.size()));
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
hdl/hhjc_pkg.sv
hdl/hhjc_front.sv
hdl/hhjc_queue.sv
hdl/hhjc_back.sv
hdl/http_header_to_json_converter.sv
tb/tb_http_header_to_json_converter.sv
